>>> hdl/frtm_pkg.sv
// Shared constants for the frame rate and throughput meter.
// Used by the channel interfaces, the divider and the top level.
package frtm_pkg;

  localparam int WINDOW     = 16;
  localparam int RING_IDX_W = $clog2(WINDOW);
  localparam int FILL_W     = $clog2(WINDOW + 1);

  localparam int STAMP_W = 48;
  localparam int BYTES_W = 16;
  localparam int TPS_W   = 30;
  localparam int RATE_W  = 32;
  localparam int TOTAL_W = 32;
  localparam int FRAC_W  = 8;

  localparam logic [TPS_W-1:0] TPS_RESET = 30'd1000000;

  // Widest dividend is byte_total * ticks_per_second; widest divisor is gap * 4.
  localparam int DIV_NUM_W = TOTAL_W + TPS_W;
  localparam int DIV_DEN_W = STAMP_W + 2;
  localparam int DIV_CNT_W = $clog2(DIV_NUM_W);

  localparam int SPAN_PROD_W = RING_IDX_W + TPS_W;

endpackage

>>> hdl/frtm_if.sv
// Channel interfaces of the frame rate and throughput meter.
// Depends on frtm_pkg for the field widths.
interface frtm_in_if;
  logic                          valid;
  logic                          ready;
  logic [frtm_pkg::STAMP_W-1:0]  timestamp_ticks;
  logic [frtm_pkg::BYTES_W-1:0]  frame_bytes;

  modport source (output valid, output timestamp_ticks, output frame_bytes, input ready);
  modport sink   (input valid, input timestamp_ticks, input frame_bytes, output ready);
endinterface

interface frtm_out_if;
  logic                          valid;
  logic                          ready;
  logic [frtm_pkg::RATE_W-1:0]   instant_rate;
  logic [frtm_pkg::RATE_W-1:0]   average_rate;
  logic [frtm_pkg::RATE_W-1:0]   throughput_kbps;
  logic                          rate_valid;
  logic [frtm_pkg::BYTES_W-1:0]  bytes_echo;

  modport source (output valid, output instant_rate, output average_rate,
                  output throughput_kbps, output rate_valid, output bytes_echo,
                  input ready);
  modport sink   (input valid, input instant_rate, input average_rate,
                  input throughput_kbps, input rate_valid, input bytes_echo,
                  output ready);
endinterface

interface frtm_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [frtm_pkg::TPS_W-1:0]    ticks_per_second;

  modport source (output valid, output ticks_per_second, input ready);
  modport sink   (input valid, input ticks_per_second, output ready);
endinterface

>>> hdl/frtm_div.sv
// Radix-2 restoring divider with a quotient that saturates at 32 bits.
// Depends on frtm_pkg for the operand widths; one dividend bit per cycle.
module frtm_div (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  input  logic [frtm_pkg::DIV_NUM_W-1:0]   num,
  input  logic [frtm_pkg::DIV_DEN_W-1:0]   den,
  output logic                             done,
  output logic [frtm_pkg::RATE_W-1:0]      quo
);

  logic                             busy;
  logic [frtm_pkg::DIV_CNT_W-1:0]   cnt;
  logic [frtm_pkg::DIV_NUM_W-1:0]   num_sh;
  logic [frtm_pkg::DIV_DEN_W-1:0]   rem;
  logic [frtm_pkg::RATE_W-1:0]      q;
  logic                             ovf;

  logic [frtm_pkg::DIV_DEN_W:0]     trial;
  logic [frtm_pkg::DIV_DEN_W:0]     diff;
  logic                             fits;

  assign trial = {rem, num_sh[frtm_pkg::DIV_NUM_W-1]};
  assign fits  = trial >= {1'b0, den};
  assign diff  = trial - {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= frtm_pkg::DIV_CNT_W'(frtm_pkg::DIV_NUM_W - 1);
      end else if (busy) begin
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt - 1'b1;
        end
      end
    end
  end

  // Any quotient bit that falls off the top of q means the result saturates.
  always_ff @(posedge clk) begin
    if (start) begin
      num_sh <= num;
      rem    <= '0;
      q      <= '0;
      ovf    <= 1'b0;
    end else if (busy) begin
      num_sh <= {num_sh[frtm_pkg::DIV_NUM_W-2:0], 1'b0};
      rem    <= fits ? diff[frtm_pkg::DIV_DEN_W-1:0] : trial[frtm_pkg::DIV_DEN_W-1:0];
      q      <= {q[frtm_pkg::RATE_W-2:0], fits};
      ovf    <= ovf | q[frtm_pkg::RATE_W-1];
    end
  end

  assign quo = ovf ? {frtm_pkg::RATE_W{1'b1}} : q;

endmodule

>>> hdl/frame_rate_throughput_meter.sv
// Top level of the frame rate and throughput meter: timestamp ring memory,
// counters, products and three frtm_div instances. Depends on frtm_pkg, frtm_if.
//
//   channel  | role  | word
//   ---------+-------+-----------------------------------------------------------
//   frames   | sink  | timestamp_ticks, frame_bytes
//   results  | source| instant_rate, average_rate, throughput_kbps, rate_valid,
//            |       | bytes_echo
//   cfg      | sink  | ticks_per_second (ready whenever rst is low)
//
// One frame at a time: accept (reading the oldest stamp), the products, a start
// step, the bit-serial divisions in the three dividers, which run in parallel, a
// step to see the dividers finish and one to load the result register, which
// waits while an unread word sits there; then the next word is accepted.
// A finished word waits in the result register while the next frame is taken.
// Reset (rst, synchronous) empties the ring, clears the byte total and restores
// ticks_per_second to 1000000.
module frame_rate_throughput_meter (
  input  logic          clk,
  input  logic          rst,
  frtm_in_if.sink       frames,
  frtm_out_if.source    results,
  frtm_cfg_if.sink      cfg
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_MUL   = 3'd1;
  localparam logic [2:0] ST_START = 3'd2;
  localparam logic [2:0] ST_WAIT  = 3'd3;
  localparam logic [2:0] ST_HOLD  = 3'd4;

  logic [2:0] state;

  // Configuration and running state.
  logic [frtm_pkg::TPS_W-1:0]       tps;
  logic [frtm_pkg::RING_IDX_W-1:0]  ring_position;
  logic [frtm_pkg::FILL_W-1:0]      frames_seen;
  logic [frtm_pkg::STAMP_W-1:0]     previous_stamp;
  logic                             have_previous;
  logic [frtm_pkg::TOTAL_W-1:0]     byte_total;

  logic [frtm_pkg::STAMP_W-1:0]     stamp_ring [frtm_pkg::WINDOW];
  logic [frtm_pkg::STAMP_W-1:0]     oldest_stamp;

  // Per-frame working registers.
  logic [frtm_pkg::STAMP_W-1:0]     now_r;
  logic [frtm_pkg::BYTES_W-1:0]     bytes_r;
  logic [frtm_pkg::STAMP_W-1:0]     gap_r;
  logic                             rate_ok;
  logic [frtm_pkg::FILL_W-1:0]      k_r;
  logic [frtm_pkg::DIV_NUM_W-1:0]   thr_prod;
  logic [frtm_pkg::SPAN_PROD_W-1:0] avg_prod;
  logic [frtm_pkg::STAMP_W-1:0]     span_r;
  logic                             span_ok;

  // Result register.
  logic                             out_valid;
  logic [frtm_pkg::RATE_W-1:0]      out_inst;
  logic [frtm_pkg::RATE_W-1:0]      out_avg;
  logic [frtm_pkg::RATE_W-1:0]      out_thr;
  logic                             out_rate_valid;
  logic [frtm_pkg::BYTES_W-1:0]     out_bytes;

  logic                             in_accept;
  logic                             out_load;
  logic [frtm_pkg::RING_IDX_W-1:0]  pos_next;
  logic [frtm_pkg::FILL_W-1:0]      fill_next;
  logic [frtm_pkg::FILL_W:0]        pos_ext;
  logic [frtm_pkg::FILL_W:0]        fill_ext;
  logic [frtm_pkg::FILL_W:0]        oldest_ext;
  logic [frtm_pkg::RING_IDX_W-1:0]  oldest_idx;
  logic [frtm_pkg::TOTAL_W:0]       total_sum;
  logic [frtm_pkg::FILL_W-1:0]      k_less;

  logic                             div_start;
  logic [frtm_pkg::DIV_NUM_W-1:0]   inst_num;
  logic [frtm_pkg::DIV_NUM_W-1:0]   avg_num;
  logic [frtm_pkg::DIV_DEN_W-1:0]   inst_den;
  logic [frtm_pkg::DIV_DEN_W-1:0]   thr_den;
  logic [frtm_pkg::DIV_DEN_W-1:0]   avg_den;
  logic                             inst_done;
  logic                             thr_done;
  logic                             avg_done;
  logic [frtm_pkg::RATE_W-1:0]      inst_quo;
  logic [frtm_pkg::RATE_W-1:0]      thr_quo;
  logic [frtm_pkg::RATE_W-1:0]      avg_quo;

  assign frames.ready = (state == ST_IDLE) && !rst;
  assign in_accept    = frames.valid && frames.ready;
  assign cfg.ready    = !rst;

  assign pos_next  = (ring_position == frtm_pkg::RING_IDX_W'(frtm_pkg::WINDOW - 1)) ?
                     '0 : ring_position + 1'b1;
  assign fill_next = (frames_seen == frtm_pkg::FILL_W'(frtm_pkg::WINDOW)) ?
                     frames_seen : frames_seen + 1'b1;

  // The oldest stamp sits k entries behind the advanced ring position.
  assign pos_ext    = (frtm_pkg::FILL_W + 1)'(pos_next);
  assign fill_ext   = (frtm_pkg::FILL_W + 1)'(fill_next);
  assign oldest_ext = (pos_ext >= fill_ext) ? pos_ext - fill_ext :
                      pos_ext + (frtm_pkg::FILL_W + 1)'(frtm_pkg::WINDOW) - fill_ext;
  assign oldest_idx = oldest_ext[frtm_pkg::RING_IDX_W-1:0];

  assign total_sum = {1'b0, byte_total} + (frtm_pkg::TOTAL_W + 1)'(frames.frame_bytes);
  assign k_less    = k_r - 1'b1;

  always_ff @(posedge clk) begin
    if (in_accept) begin
      stamp_ring[ring_position] <= frames.timestamp_ticks;
      oldest_stamp              <= stamp_ring[oldest_idx];
    end
  end

  assign out_load = (state == ST_HOLD) && (!out_valid || results.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      tps            <= frtm_pkg::TPS_RESET;
      ring_position  <= '0;
      frames_seen    <= '0;
      previous_stamp <= '0;
      have_previous  <= 1'b0;
      byte_total     <= '0;
      out_valid      <= 1'b0;
    end else begin
      if (cfg.valid && cfg.ready) begin
        tps <= cfg.ticks_per_second;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (results.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_accept) begin
            ring_position  <= pos_next;
            frames_seen    <= fill_next;
            previous_stamp <= frames.timestamp_ticks;
            have_previous  <= 1'b1;
            byte_total     <= total_sum[frtm_pkg::TOTAL_W] ?
                              {frtm_pkg::TOTAL_W{1'b1}} : total_sum[frtm_pkg::TOTAL_W-1:0];
            state          <= ST_MUL;
          end
        end
        ST_MUL: begin
          // The product below still sees the total; a valid report clears it.
          if (rate_ok) begin
            byte_total <= '0;
          end
          state <= ST_START;
        end
        ST_START: state <= ST_WAIT;
        ST_WAIT: begin
          if (inst_done && thr_done && avg_done) begin
            state <= ST_HOLD;
          end
        end
        ST_HOLD: begin
          if (out_load) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      now_r   <= frames.timestamp_ticks;
      bytes_r <= frames.frame_bytes;
      gap_r   <= frames.timestamp_ticks - previous_stamp;
      rate_ok <= have_previous && (frames.timestamp_ticks > previous_stamp);
      k_r     <= fill_next;
    end
    if (state == ST_MUL) begin
      thr_prod <= byte_total * tps;
      avg_prod <= k_less[frtm_pkg::RING_IDX_W-1:0] * tps;
      span_r   <= now_r - oldest_stamp;
      span_ok  <= (k_r >= frtm_pkg::FILL_W'(2)) && (now_r > oldest_stamp);
    end
    if (out_load) begin
      out_rate_valid <= rate_ok;
      out_bytes      <= bytes_r;
      out_inst       <= rate_ok ? inst_quo : '0;
      out_thr        <= rate_ok ? thr_quo : '0;
      out_avg        <= (rate_ok && span_ok) ? avg_quo : '0;
    end
  end

  assign div_start = (state == ST_START);
  assign inst_num  = {{(frtm_pkg::DIV_NUM_W - frtm_pkg::TPS_W - frtm_pkg::FRAC_W){1'b0}},
                      tps, {frtm_pkg::FRAC_W{1'b0}}};
  assign avg_num   = {{(frtm_pkg::DIV_NUM_W - frtm_pkg::SPAN_PROD_W - frtm_pkg::FRAC_W){1'b0}},
                      avg_prod, {frtm_pkg::FRAC_W{1'b0}}};
  assign inst_den  = {2'b00, gap_r};
  assign thr_den   = {gap_r, 2'b00};
  assign avg_den   = {2'b00, span_r};

  frtm_div u_inst_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (inst_num),
    .den   (inst_den),
    .done  (inst_done),
    .quo   (inst_quo)
  );

  frtm_div u_thr_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (thr_prod),
    .den   (thr_den),
    .done  (thr_done),
    .quo   (thr_quo)
  );

  frtm_div u_avg_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (avg_num),
    .den   (avg_den),
    .done  (avg_done),
    .quo   (avg_quo)
  );

  assign results.valid           = out_valid;
  assign results.instant_rate    = out_inst;
  assign results.average_rate    = out_avg;
  assign results.throughput_kbps = out_thr;
  assign results.rate_valid      = out_rate_valid;
  assign results.bytes_echo      = out_bytes;

endmodule
